FILE: src/bis_pkg.sv
// Shared types and constants for the bilinear image sampler.
`default_nettype none

package bis_pkg;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef logic signed [15:0] pixel_t;
	typedef logic signed [17:0] weight_t;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_X      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_Y      = 3'd5;

	localparam logic [8:0]         RST_IMAGE_WIDTH  = 9'd256;
	localparam logic [8:0]         RST_IMAGE_HEIGHT = 9'd256;
	localparam logic signed [31:0] RST_OFFSET       = 32'shFFFF0000;
	localparam logic [31:0]        RST_SCALE        = 32'd65536;

	localparam logic [1:0] NB_00 = 2'd0;
	localparam logic [1:0] NB_01 = 2'd1;
	localparam logic [1:0] NB_10 = 2'd2;
	localparam logic [1:0] NB_11 = 2'd3;

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 8;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

	localparam weight_t            WEIGHT_ONE = 18'sd65536;
	localparam int                 ROUND_HALF = 32768;
	localparam logic signed [31:0] SAT_MAX    = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SAT_MIN    = 32'sh80000000;

	typedef struct packed {
		logic [8:0]         image_width;
		logic [8:0]         image_height;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic [31:0]        scale_x;
		logic [31:0]        scale_y;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] nb_ok;
		pixel_t     value;
		weight_t    wx;
		weight_t    fx;
		weight_t    wy;
		weight_t    fy;
	} entry_t;

endpackage

`default_nettype wire

FILE: src/bis_front.sv
// Front end: accepts beats, maps sample points and classifies neighbours.
`default_nettype none

module bis_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bis_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [7:0]          pixel_row,
	input  logic [7:0]          pixel_col,
	input  logic signed [15:0]  pixel_value,
	input  logic signed [31:0]  query_x,
	input  logic signed [31:0]  query_y,
	input  logic                q_pop,
	output logic                push,
	output bis_pkg::entry_t     ent,
	output logic [RW-1:0]       row0,
	output logic [RW-1:0]       row1,
	output logic [CW-1:0]       col0,
	output logic [CW-1:0]       col1
);
	import bis_pkg::*;

	logic              accept;
	logic [QCNT_W-1:0] credit_q;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;

	kind_t              kind_s1, kind_s2, kind_s3, kind_s4;
	logic [7:0]         row_s1, row_s2, row_s3, row_s4;
	logic [7:0]         col_s1, col_s2, col_s3, col_s4;
	pixel_t             val_s1, val_s2, val_s3, val_s4;
	logic signed [32:0] sx_s1, sy_s1;
	logic               negx_s2, negy_s2, negx_s3, negy_s3;
	logic [32:0]        magx_s2, magy_s2;
	logic [63:0]        px_s3, py_s3;
	logic signed [33:0] basex_s4, basey_s4;
	logic signed [16:0] fracx_s4, fracy_s4;

	logic [63:0]        prod_x, prod_y;
	logic signed [33:0] bx, by;
	logic signed [16:0] fx17, fy17;
	logic signed [33:0] lim_w, lim_h, x1, y1;
	logic               okx0, okx1, oky0, oky1, ld_ok;
	entry_t             ent_d, ent_s5;
	logic [RW-1:0]      row0_d, row1_d, row0_s5, row1_s5;
	logic [CW-1:0]      col0_d, col1_d, col0_s5, col1_s5;

	assign in_stall = (credit_q == QCNT_W'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
		end else begin
			credit_q <= credit_q + QCNT_W'(accept) - QCNT_W'(q_pop);
			v_s1     <= accept;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
		end
	end

	always_comb begin
		prod_x = magx_s2[31:0] * cfg.scale_x;
		prod_y = magy_s2[31:0] * cfg.scale_y;
		bx     = $signed({2'b00, px_s3[63:32]});
		by     = $signed({2'b00, py_s3[63:32]});
		fx17   = $signed({1'b0, px_s3[31:16]});
		fy17   = $signed({1'b0, py_s3[31:16]});
	end

	always_comb begin
		lim_w = (cfg.image_width < MAX_WIDTH) ? 34'(cfg.image_width) : 34'(MAX_WIDTH);
		lim_h = (cfg.image_height < MAX_HEIGHT) ? 34'(cfg.image_height) : 34'(MAX_HEIGHT);
		x1    = basex_s4 + 34'sd1;
		y1    = basey_s4 + 34'sd1;
		okx0  = !basex_s4[33] && (basex_s4 < lim_w);
		okx1  = !x1[33] && (x1 < lim_w);
		oky0  = !basey_s4[33] && (basey_s4 < lim_h);
		oky1  = !y1[33] && (y1 < lim_h);
		ld_ok = (int'(row_s4) < MAX_HEIGHT) && (int'(col_s4) < MAX_WIDTH);

		ent_d.kind  = kind_s4;
		ent_d.value = val_s4;
		ent_d.fx    = 18'(fracx_s4);
		ent_d.wx    = WEIGHT_ONE - 18'(fracx_s4);
		ent_d.fy    = 18'(fracy_s4);
		ent_d.wy    = WEIGHT_ONE - 18'(fracy_s4);
		if (kind_s4 == KIND_LOAD) begin
			ent_d.nb_ok = {3'b000, ld_ok};
			row0_d      = RW'(row_s4);
			row1_d      = RW'(row_s4);
			col0_d      = CW'(col_s4);
			col1_d      = CW'(col_s4);
		end else begin
			ent_d.nb_ok[NB_00] = oky0 && okx0;
			ent_d.nb_ok[NB_01] = oky0 && okx1;
			ent_d.nb_ok[NB_10] = oky1 && okx0;
			ent_d.nb_ok[NB_11] = oky1 && okx1;
			row0_d             = basey_s4[RW-1:0];
			row1_d             = y1[RW-1:0];
			col0_d             = basex_s4[CW-1:0];
			col1_d             = x1[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_t'(kind);
		row_s1  <= pixel_row;
		col_s1  <= pixel_col;
		val_s1  <= pixel_value;
		sx_s1   <= 33'(query_x) + 33'(cfg.offset_x);
		sy_s1   <= 33'(query_y) + 33'(cfg.offset_y);

		kind_s2 <= kind_s1;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		val_s2  <= val_s1;
		negx_s2 <= sx_s1[32];
		negy_s2 <= sy_s1[32];
		magx_s2 <= sx_s1[32] ? 33'(-sx_s1) : 33'(sx_s1);
		magy_s2 <= sy_s1[32] ? 33'(-sy_s1) : 33'(sy_s1);

		kind_s3 <= kind_s2;
		row_s3  <= row_s2;
		col_s3  <= col_s2;
		val_s3  <= val_s2;
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		px_s3   <= magx_s2[32] ? {cfg.scale_x, 32'h0} : prod_x;
		py_s3   <= magy_s2[32] ? {cfg.scale_y, 32'h0} : prod_y;

		kind_s4  <= kind_s3;
		row_s4   <= row_s3;
		col_s4   <= col_s3;
		val_s4   <= val_s3;
		basex_s4 <= negx_s3 ? -bx : bx;
		basey_s4 <= negy_s3 ? -by : by;
		fracx_s4 <= negx_s3 ? -fx17 : fx17;
		fracy_s4 <= negy_s3 ? -fy17 : fy17;

		ent_s5  <= ent_d;
		row0_s5 <= row0_d;
		row1_s5 <= row1_d;
		col0_s5 <= col0_d;
		col1_s5 <= col1_d;
	end

	assign push = v_s5;
	assign ent  = ent_s5;
	assign row0 = row0_s5;
	assign row1 = row1_s5;
	assign col0 = col0_s5;
	assign col1 = col1_s5;

endmodule

`default_nettype wire

FILE: src/bis_queue.sv
// Short queue between front end and back end.
`default_nettype none

module bis_queue #(
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic              nonempty,
	output logic [DATA_W-1:0] rdata
);
	import bis_pkg::*;

	logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end

	assign nonempty = (cnt_q != '0);
	assign rdata    = slot_q[rd_q];

endmodule

`default_nettype wire

FILE: src/bis_back.sv
// Back end: image memory, neighbour reads, blend pipeline and result buffer.
`default_nettype none

module bis_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  bis_pkg::entry_t    head,
	input  logic [RW-1:0]      head_row0,
	input  logic [RW-1:0]      head_row1,
	input  logic [CW-1:0]      head_col0,
	input  logic [CW-1:0]      head_col1,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] interpolated_value
);
	import bis_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	pixel_t mem [DEPTH];

	entry_t        cur_q;
	logic [RW-1:0] row0_q, row1_q;
	logic [CW-1:0] col0_q, col1_q;
	logic          cur_v_q;
	logic [1:0]    cnt_q;
	logic [OCNT_W-1:0] pend_q;

	logic          cur_query, cur_done, head_ok, rd_en, wr_en, nb_ok;
	logic [RW-1:0] row_sel;
	logic [CW-1:0] col_sel;
	logic [AW-1:0] addr;

	logic               rd_v_s1, rd_ok_s1;
	logic [1:0]         rd_nb_s1;
	pixel_t             rdata_s1;
	weight_t            wx_s1, fx_s1, wy_s1, fy_s1;
	pixel_t             px;
	pixel_t             p00_q, p01_q, p10_q;
	logic               fire;

	logic               v_s2, v_s3, v_s4, v_s5;
	logic signed [33:0] pr00_s2, pr01_s2, pr10_s2, pr11_s2;
	weight_t            wy_s2, fy_s2, wy_s3, fy_s3;
	logic signed [34:0] top_s3, bot_s3;
	logic signed [52:0] m0_s4, m1_s4;
	logic signed [53:0] r_s5;
	logic signed [37:0] qv;
	logic signed [31:0] res;

	logic signed [31:0] ofifo_q [OUT_DEPTH];
	logic [OPTR_W-1:0]  owr_q, ord_q;
	logic [OCNT_W-1:0]  ocnt_q;
	logic               out_take;

	assign cur_query = cur_v_q && (cur_q.kind == KIND_QUERY);
	assign cur_done  = cur_v_q && ((cur_q.kind == KIND_LOAD) || (cnt_q == NB_11));
	assign head_ok   = (head.kind == KIND_LOAD) || (pend_q < OCNT_W'(OUT_DEPTH));
	assign q_pop     = q_valid && (!cur_v_q || cur_done) && head_ok;
	assign out_take  = out_valid && !out_stall;

	always_comb begin
		row_sel = cnt_q[1] ? row1_q : row0_q;
		col_sel = cnt_q[0] ? col1_q : col0_q;
		nb_ok   = cur_q.nb_ok[cnt_q];
		addr    = AW'(row_sel) * AW'(MAX_WIDTH) + AW'(col_sel);
		rd_en   = cur_query && nb_ok;
		wr_en   = cur_v_q && (cur_q.kind == KIND_LOAD) && nb_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			cnt_q   <= NB_00;
			pend_q  <= '0;
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			owr_q   <= '0;
			ord_q   <= '0;
			ocnt_q  <= '0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
				cnt_q   <= NB_00;
			end else if (cur_done) begin
				cur_v_q <= 1'b0;
			end else if (cur_query) begin
				cnt_q <= cnt_q + 2'd1;
			end
			pend_q  <= pend_q + OCNT_W'(q_pop && (head.kind == KIND_QUERY))
				- OCNT_W'(out_take);
			rd_v_s1 <= cur_query;
			v_s2    <= fire;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			if (v_s5) owr_q <= owr_q + OPTR_W'(1);
			if (out_take) ord_q <= ord_q + OPTR_W'(1);
			ocnt_q <= ocnt_q + OCNT_W'(v_s5) - OCNT_W'(out_take);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= head;
			row0_q <= head_row0;
			row1_q <= head_row1;
			col0_q <= head_col0;
			col1_q <= head_col1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= cur_q.value;
		if (rd_en) rdata_s1 <= mem[addr];
	end

	always_ff @(posedge clk) begin
		rd_nb_s1 <= cnt_q;
		rd_ok_s1 <= nb_ok;
		wx_s1    <= cur_q.wx;
		fx_s1    <= cur_q.fx;
		wy_s1    <= cur_q.wy;
		fy_s1    <= cur_q.fy;
	end

	assign px   = rd_ok_s1 ? rdata_s1 : '0;
	assign fire = rd_v_s1 && (rd_nb_s1 == NB_11);

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			case (rd_nb_s1)
				NB_00: p00_q <= px;
				NB_01: p01_q <= px;
				NB_10: p10_q <= px;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pr00_s2 <= wx_s1 * p00_q;
		pr01_s2 <= fx_s1 * p01_q;
		pr10_s2 <= wx_s1 * p10_q;
		pr11_s2 <= fx_s1 * px;
		wy_s2   <= wy_s1;
		fy_s2   <= fy_s1;

		top_s3 <= 35'(pr00_s2) + 35'(pr01_s2);
		bot_s3 <= 35'(pr10_s2) + 35'(pr11_s2);
		wy_s3  <= wy_s2;
		fy_s3  <= fy_s2;

		m0_s4 <= wy_s3 * top_s3;
		m1_s4 <= fy_s3 * bot_s3;

		r_s5 <= 54'(m0_s4) + 54'(m1_s4) + 54'(ROUND_HALF);
	end

	always_comb begin
		qv = r_s5[53:16];
		if (qv[37:31] == {7{qv[37]}}) begin
			res = qv[31:0];
		end else begin
			res = qv[37] ? SAT_MIN : SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5) ofifo_q[owr_q] <= res;
	end

	assign out_valid          = (ocnt_q != '0);
	assign interpolated_value = ofifo_q[ord_q];

endmodule

`default_nettype wire

FILE: src/bilinear_image_sampler.sv
// The single image memory port serves the four neighbour reads of a query in
// turn; the back end takes the next queued beat only once the current beat
// is done.
// Up to 8 beats queue between front and back, up to 8 results wait at the output.
// Reset clears control state and restores register defaults; the image
// memory is not cleared and holds undefined data until written.
`default_nettype none

module bilinear_image_sampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         pixel_row,
	input  logic [7:0]         pixel_col,
	input  logic signed [15:0] pixel_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] interpolated_value
);
	import bis_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int QW = $bits(entry_t) + 2 * RW + 2 * CW;

	cfg_t          cfg_q;
	logic          f_push, q_pop, q_nonempty;
	entry_t        f_ent, h_ent;
	logic [RW-1:0] f_row0, f_row1, h_row0, h_row1;
	logic [CW-1:0] f_col0, f_col1, h_col0, h_col1;
	logic [QW-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.offset_x     <= RST_OFFSET;
			cfg_q.offset_y     <= RST_OFFSET;
			cfg_q.scale_x      <= RST_SCALE;
			cfg_q.scale_y      <= RST_SCALE;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[8:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[8:0];
				REG_OFFSET_X:     cfg_q.offset_x     <= cfg_data;
				REG_OFFSET_Y:     cfg_q.offset_y     <= cfg_data;
				REG_SCALE_X:      cfg_q.scale_x      <= cfg_data;
				REG_SCALE_Y:      cfg_q.scale_y      <= cfg_data;
				default: ;
			endcase
		end
	end

	bis_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.pixel_value (pixel_value),
		.query_x     (query_x),
		.query_y     (query_y),
		.q_pop       (q_pop),
		.push        (f_push),
		.ent         (f_ent),
		.row0        (f_row0),
		.row1        (f_row1),
		.col0        (f_col0),
		.col1        (f_col1)
	);

	assign q_wdata = {f_row1, f_row0, f_col1, f_col0, f_ent};
	assign {h_row1, h_row0, h_col1, h_col0, h_ent} = q_rdata;

	bis_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	bis_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_valid            (q_nonempty),
		.head               (h_ent),
		.head_row0          (h_row0),
		.head_row1          (h_row1),
		.head_col0          (h_col0),
		.head_col1          (h_col1),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.interpolated_value (interpolated_value)
	);

endmodule

`default_nettype wire
